@@ hw/rtl/fir_rh_pkg.sv @@
// Shared constants, state encoding and control types for the ring-history FIR filter.
package fir_rh_pkg;

  localparam int unsigned MAX_TAPS_DEF     = 256;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned COEF_WIDTH_DEF   = 16;

  // Width of the wrapping accumulator for the sum of products.
  localparam int unsigned ACC_WIDTH = 40;

  // Operation codes carried by the op field of an input word.
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND
  } fir_rh_state_e;

  // Control handed from the sequencer to the multiply-accumulate datapath.
  typedef struct packed {
    logic start;
    logic issue;
    logic first;
  } fir_rh_mac_ctrl_t;

endpackage

@@ hw/rtl/fir_rh_in_if.sv @@
// Input channel: valid/ready handshake carrying one sample or coefficient-write word.
interface fir_rh_in_if
  import fir_rh_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH   = COEF_WIDTH_DEF,
  parameter int unsigned IDX_WIDTH    = $clog2(MAX_TAPS_DEF)
);
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic        [IDX_WIDTH-1:0]    coef_index;
  logic signed [COEF_WIDTH-1:0]   coef_value;

  modport source (output valid, op, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, op, sample_in, coef_index, coef_value, output ready);
endinterface

@@ hw/rtl/fir_rh_out_if.sv @@
// Output channel: valid/ready handshake carrying one filtered sample.
interface fir_rh_out_if
  import fir_rh_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

@@ hw/rtl/fir_rh_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module fir_rh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/fir_rh_mac.sv @@
// Multiply-accumulate datapath with rounding and saturation of the final sum.
module fir_rh_mac
  import fir_rh_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH   = COEF_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fir_rh_mac_ctrl_t               ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_now_i,
  input  logic signed [SAMPLE_WIDTH-1:0] hist_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_i,
  output logic                           busy_o,
  output logic signed [SAMPLE_WIDTH-1:0] result_o
);

  localparam int unsigned PW    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int unsigned EXT_W = (PW > ACC_WIDTH) ? PW : ACC_WIDTH;
  localparam int unsigned RW    = ACC_WIDTH + 1;

  localparam logic signed [RW-1:0] RND    = RW'(1) <<< (COEF_WIDTH - 2);
  localparam logic signed [RW-1:0] SAT_HI =
    {{(RW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  logic                           s1_valid_q, s1_first_q, s2_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] x_sel;
  logic signed [PW-1:0]           prod_d, prod_q;
  logic signed [EXT_W-1:0]        prod_ext;
  logic signed [ACC_WIDTH-1:0]    acc_d, acc_q;
  logic signed [RW-1:0]           sum_rnd, sum_shr;

  // The newest sample is not yet in the history, so tap zero takes it directly.
  assign x_sel    = s1_first_q ? x_now_i : hist_i;
  assign prod_d   = x_sel * coef_i;
  assign prod_ext = EXT_W'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.start) begin
      acc_d = '0;
    end else if (s2_valid_q) begin
      acc_d = acc_q + prod_ext[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_first_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= ctrl_i.issue;
      s1_first_q <= ctrl_i.first;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  // Round half up to the output format, then clamp to the sample range.
  assign sum_rnd = RW'(acc_q) + RND;
  assign sum_shr = sum_rnd >>> (COEF_WIDTH - 1);

  always_comb begin
    if (sum_shr > SAT_HI) begin
      result_o = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (sum_shr < SAT_LO) begin
      result_o = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      result_o = sum_shr[SAMPLE_WIDTH-1:0];
    end
  end

  assign busy_o = s1_valid_q | s2_valid_q;

endmodule

@@ hw/rtl/fir_filter_ring_history.sv @@
// Top level of the direct-form FIR filter with a circular sample history.
//
// Input words arrive on in_if (valid/ready). A word with op set to the
// coefficient code writes one tap into the coefficient memory and yields no
// output. A word with op set to the filter code
// yields one word on out_if: the sum of coefficient times sample over the
// configured number of taps, rounded half up and saturated to the sample width.
// The filter word occupies the block while the single multiplier steps one tap
// per cycle through the two memories; no input word is taken meanwhile.
// The tap count is written through cfg_we_i/cfg_wdata_i; the user must do so only
// while the block is idle, as the block does not enforce it. Zero acts as one tap
// and values above MAX_TAPS act as MAX_TAPS. After reset both memories are cleared,
// one entry per cycle; no input word is accepted until that sweep is done.
// The finished sample sits in an output register, so a new input word can be
// taken while the receiver stalls; a following filter word waits in its final
// step until the previous output has been taken.
module fir_filter_ring_history
  import fir_rh_pkg::*;
#(
  parameter int unsigned MAX_TAPS     = MAX_TAPS_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH   = COEF_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [$clog2(MAX_TAPS + 1)-1:0]  cfg_wdata_i,
  fir_rh_in_if.sink                        in_if,
  fir_rh_out_if.source                     out_if
);

  localparam int unsigned IDX_W = $clog2(MAX_TAPS);
  localparam int unsigned TC_W  = $clog2(MAX_TAPS + 1);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TAPS - 1);
  localparam logic [IDX_W:0]   IDX_LIM  = (IDX_W + 1)'(MAX_TAPS);
  localparam logic [TC_W-1:0]  TC_MAX   = TC_W'(MAX_TAPS);

  fir_rh_state_e state_q, state_d;
  fir_rh_mac_ctrl_t mac_ctrl;

  logic [TC_W-1:0]                tap_count_q;
  logic [IDX_W-1:0]               clr_cnt_q, clr_cnt_d;
  logic [IDX_W-1:0]               issue_cnt_q, issue_cnt_d;
  logic [IDX_W-1:0]               hist_ptr_q, hist_ptr_d;
  logic [IDX_W-1:0]               last_q, last_d;
  logic [IDX_W-1:0]               wp_q, wp_d;
  logic signed [SAMPLE_WIDTH-1:0] x_now_q, x_now_d;
  logic                           out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] out_q, out_d;

  logic                           in_accept, in_ready;
  logic                           coef_we, hist_we, round_fire, clearing;
  logic [IDX_W-1:0]               coef_waddr, hist_waddr;
  logic signed [COEF_WIDTH-1:0]   coef_wdata, coef_rd;
  logic signed [SAMPLE_WIDTH-1:0] hist_wdata, hist_rd, mac_result;
  logic                           mac_busy;
  logic [IDX_W-1:0]               last_sat;

  assign in_accept = in_if.valid & in_ready;
  assign clearing  = (state_q == ST_CLEAR);

  // Last tap index to visit, after folding zero and oversized counts into range.
  always_comb begin
    if (tap_count_q == '0) begin
      last_sat = '0;
    end else if (tap_count_q > TC_MAX) begin
      last_sat = IDX_LAST;
    end else begin
      last_sat = IDX_W'(tap_count_q - TC_W'(1));
    end
  end

  always_comb begin
    state_d       = state_q;
    clr_cnt_d     = clr_cnt_q;
    issue_cnt_d   = issue_cnt_q;
    hist_ptr_d    = hist_ptr_q;
    last_d        = last_q;
    wp_d          = wp_q;
    x_now_d       = x_now_q;
    out_valid_d   = out_valid_q & ~out_if.ready;
    out_d         = out_q;
    in_ready      = 1'b0;
    round_fire    = 1'b0;
    mac_ctrl      = '0;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + IDX_W'(1);
        if (clr_cnt_q == IDX_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_accept && (in_if.op == OP_FILTER)) begin
          mac_ctrl.start = 1'b1;
          x_now_d        = in_if.sample_in;
          issue_cnt_d    = '0;
          last_d         = last_sat;
          // Tap zero reads this slot but uses the new sample instead, so tap one
          // lands on the most recent stored sample.
          hist_ptr_d     = wp_q;
          state_d        = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_ctrl.issue = 1'b1;
        mac_ctrl.first = (issue_cnt_q == '0);
        issue_cnt_d    = issue_cnt_q + IDX_W'(1);
        hist_ptr_d     = (hist_ptr_q == '0) ? IDX_LAST : hist_ptr_q - IDX_W'(1);
        if (issue_cnt_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (!out_valid_q || out_if.ready) begin
          round_fire  = 1'b1;
          out_valid_d = 1'b1;
          out_d       = mac_result;
          wp_d        = (wp_q == IDX_LAST) ? '0 : wp_q + IDX_W'(1);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      issue_cnt_q <= '0;
      hist_ptr_q  <= '0;
      last_q      <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
      tap_count_q <= TC_W'(1);
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      issue_cnt_q <= issue_cnt_d;
      hist_ptr_q  <= hist_ptr_d;
      last_q      <= last_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tap_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_now_q <= x_now_d;
    out_q   <= out_d;
  end

  // Memory write ports: the clearing sweep has priority over normal traffic.
  assign coef_we    = clearing |
                      (in_accept && (in_if.op == OP_COEF) && ({1'b0, in_if.coef_index} < IDX_LIM));
  assign coef_waddr = clearing ? clr_cnt_q : in_if.coef_index;
  assign coef_wdata = clearing ? '0 : in_if.coef_value;

  assign hist_we    = clearing | round_fire;
  assign hist_waddr = clearing ? clr_cnt_q : wp_q;
  assign hist_wdata = clearing ? '0 : x_now_q;

  fir_rh_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i (issue_cnt_q),
    .rdata_o (coef_rd)
  );

  fir_rh_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_ptr_q),
    .rdata_o (hist_rd)
  );

  fir_rh_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .x_now_i  (x_now_q),
    .hist_i   (hist_rd),
    .coef_i   (coef_rd),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  assign in_if.ready       = in_ready;
  assign out_if.valid      = out_valid_q;
  assign out_if.sample_out = out_q;

  // The sum must be complete before it is rounded and handed out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> !mac_busy)
    else $error("rounding started with products still in flight");

  // The tap counter never runs past the last tap of the current word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (issue_cnt_q <= last_q))
    else $error("tap counter ran past the last tap");

  // Coefficients are never rewritten while products are still being formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (coef_we && !clearing) |-> !mac_busy)
    else $error("coefficient write overlapped the accumulation");

  // A finished sum always lands in the output register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    round_fire |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("finished word did not reach the output register");

endmodule

@@ tb/tb_fir_filter_ring_history.sv @@
// Self-checking testbench for the ring-history FIR filter, with its own model of the filter.
`timescale 1ns / 100ps

module tb_fir_filter_ring_history;
  import fir_rh_pkg::*;

  localparam int unsigned CFG_WIDTH   = $clog2(MAX_TAPS_DEF + 1);
  localparam int unsigned IDX_WIDTH   = $clog2(MAX_TAPS_DEF);
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned WORDS_PHASE = 63;
  localparam longint      CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic                               op;
    logic signed [SAMPLE_WIDTH_DEF-1:0] sample;
    logic        [IDX_WIDTH-1:0]        idx;
    logic signed [COEF_WIDTH_DEF-1:0]   coef;
  } fir_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_WIDTH-1:0] cfg_wdata_i;

  fir_rh_in_if  in_bus ();
  fir_rh_out_if out_bus ();

  fir_filter_ring_history DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_bus),
    .out_if      (out_bus)
  );

  // Mirror of the filter state.
  logic signed [SAMPLE_WIDTH_DEF-1:0] hist_mirror [MAX_TAPS_DEF];
  logic signed [COEF_WIDTH_DEF-1:0]   coef_mirror [MAX_TAPS_DEF];
  logic [IDX_WIDTH-1:0]               head_mirror;
  int unsigned                        tap_reg_mirror;

  fir_word_t                          pending_words [$];
  logic signed [SAMPLE_WIDTH_DEF-1:0] expected_samples [$];
  fir_word_t                          next_word;

  int unsigned words_queued, words_taken;
  int unsigned filter_words, coef_words, samples_checked, tap_writes, mismatch_count;
  int unsigned in_gap_left, out_gap_left, hold_left;
  longint      cycle_count;
  bit          in_fire_q;
  bit          idling_on;
  bit          want_long_hold;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned effective_taps(input int unsigned reg_value);
    if (reg_value == 0) return 1;
    if (reg_value > MAX_TAPS_DEF) return MAX_TAPS_DEF;
    return reg_value;
  endfunction

  // Updates the mirror for one accepted word and queues the filtered sample it yields.
  task automatic model_word(input fir_word_t w);
    logic signed [ACC_WIDTH-1:0]        acc;
    logic signed [SAMPLE_WIDTH_DEF-1:0] x;
    logic signed [SAMPLE_WIDTH_DEF-1:0] y;
    longint                             prod;
    longint                             rounded;
    int unsigned                        n;
    if (w.op == OP_COEF) begin
      coef_mirror[w.idx] = w.coef;
    end else begin
      n = effective_taps(tap_reg_mirror);
      acc = '0;
      for (int unsigned i = 0; i < n; i++) begin
        x = (i == 0) ? w.sample : hist_mirror[head_mirror - IDX_WIDTH'(i)];
        prod = longint'(x) * longint'(coef_mirror[i]);
        acc += prod[ACC_WIDTH-1:0];
      end
      // Round half up to Q1.15, then clamp to the sample range.
      rounded = (longint'(acc) + (64'sd1 <<< (COEF_WIDTH_DEF - 2))) >>> (COEF_WIDTH_DEF - 1);
      if (rounded > 32767) y = 16'sh7FFF;
      else if (rounded < -32768) y = 16'sh8000;
      else y = rounded[SAMPLE_WIDTH_DEF-1:0];
      expected_samples.push_back(y);
      hist_mirror[head_mirror] = w.sample;
      head_mirror++;
    end
  endtask

  function automatic logic signed [15:0] pick_value(input int unsigned shift_max);
    logic signed [15:0] v;
    case ($urandom_range(0, 11))
      0:       v = 16'sh7FFF;
      1:       v = 16'sh8000;
      2:       v = 16'sh0000;
      3:       v = -16'sd1;
      default: v = $signed(16'($urandom)) >>> $urandom_range(0, shift_max);
    endcase
    return v;
  endfunction

  task automatic queue_filter(input logic signed [15:0] x);
    fir_word_t w;
    w.op     = OP_FILTER;
    w.sample = x;
    w.idx    = IDX_WIDTH'($urandom);
    w.coef   = 16'($urandom);
    pending_words.push_back(w);
    words_queued++;
    filter_words++;
  endtask

  task automatic queue_coef(input int unsigned idx, input logic signed [15:0] c);
    fir_word_t w;
    w.op     = OP_COEF;
    w.sample = 16'($urandom);
    w.idx    = IDX_WIDTH'(idx);
    w.coef   = c;
    pending_words.push_back(w);
    words_queued++;
    coef_words++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (words_taken != words_queued || expected_samples.size() != 0);
  endtask

  // A coefficient word yields nothing, so after draining we also sit out one full filter pass.
  task automatic write_tap_count(input int unsigned value);
    wait_drained();
    repeat (effective_taps(tap_reg_mirror) + 16) @(negedge clk_i);
    cfg_wdata_i <= CFG_WIDTH'(value);
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i       <= 1'b0;
    tap_reg_mirror  = value;
    tap_writes++;
    @(posedge clk_i);
  endtask

  // Input driver.
  always @(negedge clk_i) begin
    if (rst_ni && (in_fire_q || !in_bus.valid)) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        next_word = pending_words.pop_front();
        in_bus.valid      <= 1'b1;
        in_bus.op         <= next_word.op;
        in_bus.sample_in  <= next_word.sample;
        in_bus.coef_index <= next_word.idx;
        in_bus.coef_value <= next_word.coef;
        if (idling_on && $urandom_range(0, 5) == 0) in_gap_left = $urandom_range(1, 12);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Output receiver, with random stalls and one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (want_long_hold) begin
      want_long_hold = 1'b0;
      hold_left      = LONG_HOLD - 1;
      out_bus.ready <= 1'b0;
    end else if (out_gap_left > 0) begin
      out_gap_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      if (idling_on && $urandom_range(0, 7) == 0) out_gap_left = $urandom_range(1, 12);
    end
  end

  // Monitor: predicts on every accepted input word and checks every output word.
  always @(posedge clk_i) begin
    in_fire_q = rst_ni && in_bus.valid && in_bus.ready;
    if (in_fire_q) begin
      model_word('{op: in_bus.op, sample: in_bus.sample_in,
                   idx: in_bus.coef_index, coef: in_bus.coef_value});
      words_taken++;
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_samples.size() == 0) begin
        mismatch_count++;
        $display("%0t: output word %0d with none expected", $time, out_bus.sample_out);
      end else begin
        samples_checked++;
        if (out_bus.sample_out !== expected_samples[0]) begin
          mismatch_count++;
          $display("%0t: sample_out mismatch, expected %0d, got %0d",
                   $time, expected_samples[0], out_bus.sample_out);
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d samples outstanding", $time, expected_samples.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned tap_plan [22];
    int unsigned n;
    int unsigned shift_max;
    tap_plan          = '{2, 3, 1, 5, 8, 256, 4, 16, 0, 33, 6, 64, 2, 12, 257, 7,
                          128, 3, 511, 10, 4, 2};
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_bus.valid      = 1'b0;
    in_bus.op         = OP_FILTER;
    in_bus.sample_in  = '0;
    in_bus.coef_index = '0;
    in_bus.coef_value = '0;
    out_bus.ready     = 1'b0;
    for (int i = 0; i < MAX_TAPS_DEF; i++) begin
      hist_mirror[i] = '0;
      coef_mirror[i] = '0;
    end
    head_mirror    = '0;
    tap_reg_mirror = 1;
    idling_on      = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed words under the reset tap count of one: zero taps, the upper saturation
    // limit, rounding of exactly half an LSB either side of zero, the last index.
    queue_filter(16'sh7FFF);
    queue_coef(0, 16'sh8000);
    queue_filter(16'sh8000);
    queue_filter(16'sh7FFF);
    queue_coef(0, 16'sh4000);
    queue_filter(16'sd1);
    queue_filter(-16'sd1);
    queue_coef(MAX_TAPS_DEF - 1, 16'sh7FFF);
    queue_coef(1, 16'sh7FFF);
    queue_filter(16'sh0000);
    // A tap count of zero behaves as one tap.
    write_tap_count(0);
    queue_filter(16'sh7FFF);
    queue_filter(16'sh8000);
    // Counts above the memory size behave as the full memory.
    write_tap_count((1 << CFG_WIDTH) - 1);
    queue_filter(16'sh8000);
    queue_filter(16'sh8000);
    queue_filter(16'sh7FFF);
    write_tap_count(MAX_TAPS_DEF + 1);
    queue_filter(16'sh1234);

    // Random phases: each loads a set of taps, then streams samples with the odd tap rewrite.
    for (int p = 0; p < 22; p++) begin
      write_tap_count(tap_plan[p]);
      idling_on = (p < 19) && (p % 5 != 3);
      if (p == 1) want_long_hold = 1'b1;
      n = effective_taps(tap_plan[p]);
      shift_max = (n > 16) ? 10 : 4;
      if (n <= 64) begin
        for (int unsigned i = 0; i < n; i++) queue_coef(i, pick_value(shift_max));
      end else begin
        for (int i = 0; i < 16; i++)
          queue_coef($urandom_range(0, n - 1), pick_value(shift_max));
      end
      for (int i = 0; i < WORDS_PHASE; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 3) == 0) queue_coef($urandom_range(0, MAX_TAPS_DEF - 1),
                                                    pick_value(0));
          else queue_coef($urandom_range(0, n - 1), pick_value(shift_max));
        end else begin
          queue_filter(pick_value(4));
        end
      end
    end

    wait_drained();
    repeat (MAX_TAPS_DEF + 40) @(posedge clk_i);
    $display("Covered %0d filter words and %0d coefficient writes across %0d tap-count writes.",
             filter_words, coef_words, tap_writes);
    $display("Compared %0d output samples; %0d mismatches.", samples_checked, mismatch_count);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
